### hdl/cfa_pkg.sv
// package: request and response types, opcodes, status and frame state codes, csr indices
`default_nettype none
package cfa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_MARK    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_RUN    = 2'd1,
      ST_NOT_HEAD  = 2'd2,
      ST_OUT_RANGE = 2'd3
   } status_type;

   localparam logic [1:0] FS_FREE  = 2'b11;
   localparam logic [1:0] FS_HEAD  = 2'b10;
   localparam logic [1:0] FS_ALLOC = 2'b00;

   localparam logic [1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [1:0] CSR_POOL_FRAMES = 2'd1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [19:0] first_frame;
      logic [14:0] frame_count;
   } req_type;

   typedef struct packed {
      logic [19:0] result_frame;
      logic [1:0]  status;
      logic [14:0] free_frames;
   } rsp_type;

endpackage
`default_nettype wire

### hdl/contiguous_frame_allocator_unit.sv
// top level: first-fit contiguous frame allocator over a packed frame state memory
//
// a request (req_data) is taken when start is high and busy is low; busy stays
// high until the response, which appears on rsp_data for one cycle with
// rsp_valid high. the receiver cannot stall, so nothing waits downstream.
// frame states live in one memory of MAX_FRAMES/8 words, eight frames a word,
// with registered read data; every paint and release step is a read then a
// write back. allocate scans one word a cycle, then paints the run word by
// word. mark paints each word touched; release walks word by word. opcode 3
// and early errors answer straight from idle, without busy going high.
// after reset, and after a write to pool_base or pool_frames on the csr port,
// a clearing pass over every memory word sets every frame free; busy is high
// during it. csr writes are always taken (csr_ready high) and are meant only
// while the block is idle.
`default_nettype none
module contiguous_frame_allocator_unit import cfa_pkg::*; #(
   parameter int MAX_FRAMES = 16384
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        start,
   output logic              busy,
   input  wire  req_type     req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  wire  logic        csr_valid,
   output logic              csr_ready,
   input  wire  logic [1:0]  csr_index,
   input  wire  logic [19:0] csr_data
);

   localparam int WORDS = (MAX_FRAMES + 7) / 8;
   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int XW = AW + 3;
   localparam int NW = XW + 1;
   localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CLEAR = 8'b0000_0010,
      S_SCAN  = 8'b0000_0100,
      S_PRD   = 8'b0000_1000,
      S_PWR   = 8'b0001_0000,
      S_RRD   = 8'b0010_0000,
      S_RWR   = 8'b0100_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     dw_ff, dw_in;
   logic              dv_ff, dv_in;
   logic              iss_ff, iss_in;
   logic [NW-1:0]     run_ff, run_in;
   logic [NW-1:0]     cnt_ff, cnt_in;
   logic [XW-1:0]     lo_ff, lo_in;
   logic [XW-1:0]     hi_ff, hi_in;
   logic              going_ff, going_in;
   logic              is_alloc_ff, is_alloc_in;
   logic [19:0]       base_ff, base_in;
   logic [14:0]       pframes_ff, pframes_in;
   logic [NW-1:0]     free_ff, free_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [15:0]       mem [WORDS];
   logic [15:0]       rd_ff;
   logic              we;
   logic [AW-1:0]     wa, ra;
   logic [15:0]       wd;

   logic [31:0]       pf32, nsz;
   logic [NW-1:0]     n;
   logic [NW-1:0]     nm1;
   logic [AW-1:0]     last_w;

   logic [NW-1:0]     scan_run;
   logic              scan_hit;
   logic [XW-1:0]     scan_end;
   logic [XW-1:0]     scan_start;

   logic [15:0]       paint_word;
   logic [3:0]        paint_cnt;

   logic [15:0]       rel_word;
   logic [3:0]        rel_cnt;
   logic              rel_going;
   logic              rel_nothead;
   logic [NW-1:0]     next_first;

   logic [20:0]       diff;
   logic [20:0]       n21;
   logic [20:0]       cnt21;
   logic [XW-1:0]     idx;
   logic              below, past, cnt_over;

   logic              fin;
   status_type        fin_status;
   logic [19:0]       fin_frame;

   // active pool size
   always_comb begin
      pf32 = 32'(pframes_ff);
      nsz  = (pf32 > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : pf32;
      nsz  = nsz & ~32'd3;
      n    = NW'(nsz);
      nm1  = n - NW'(1);
      last_w = nm1[XW-1:3];
   end

   // range checks
   always_comb begin
      diff  = {1'b0, req_data.first_frame} - {1'b0, base_ff};
      n21   = 21'(n);
      cnt21 = 21'(req_data.frame_count);
      below = diff[20];
      past  = (diff >= n21);
      cnt_over = (cnt21 > (n21 - diff));
      idx   = XW'(diff);
   end

   // first-fit scan of one word
   always_comb begin
      logic [XW-1:0] f;
      logic          fr;
      scan_run = run_ff;
      scan_hit = 1'b0;
      scan_end = '0;
      for (int j = 0; j < 8; j++) begin
         f  = {dw_ff, 3'(j)};
         fr = (NW'(f) < n) && (rd_ff[2*j +: 2] == FS_FREE);
         if (!scan_hit) begin
            scan_run = fr ? scan_run + NW'(1) : '0;
            if (fr && scan_run == cnt_ff) begin
               scan_hit = 1'b1;
               scan_end = f;
            end
         end
      end
      scan_start = scan_end - XW'(cnt_ff) + XW'(1);
   end

   // paint head and followers over one word
   always_comb begin
      logic [XW-1:0] f;
      paint_word = rd_ff;
      paint_cnt  = '0;
      for (int j = 0; j < 8; j++) begin
         f = {addr_ff, 3'(j)};
         if (f >= lo_ff && f <= hi_ff) begin
            if (rd_ff[2*j +: 2] == FS_FREE) begin
               paint_cnt = paint_cnt + 4'd1;
            end
            paint_word[2*j +: 2] = (f == lo_ff) ? FS_HEAD : FS_ALLOC;
         end
      end
   end

   // release walk over one word
   always_comb begin
      logic [XW-1:0] f;
      logic [1:0]    st;
      rel_word    = rd_ff;
      rel_cnt     = '0;
      rel_going   = going_ff;
      rel_nothead = 1'b0;
      for (int j = 0; j < 8; j++) begin
         f  = {addr_ff, 3'(j)};
         st = rd_ff[2*j +: 2];
         if (f == lo_ff) begin
            if (st != FS_HEAD) begin
               rel_nothead = 1'b1;
            end else begin
               rel_word[2*j +: 2] = FS_FREE;
               rel_cnt   = rel_cnt + 4'd1;
               rel_going = 1'b1;
            end
         end else if (f > lo_ff) begin
            if (rel_going && (NW'(f) < n) && st == FS_ALLOC) begin
               rel_word[2*j +: 2] = FS_FREE;
               rel_cnt = rel_cnt + 4'd1;
            end else begin
               rel_going = 1'b0;
            end
         end
      end
      next_first = NW'({addr_ff, 3'b000}) + NW'(8);
   end

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      dw_in       = dw_ff;
      dv_in       = 1'b0;
      iss_in      = iss_ff;
      run_in      = run_ff;
      cnt_in      = cnt_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      going_in    = going_ff;
      is_alloc_in = is_alloc_ff;
      base_in     = base_ff;
      pframes_in  = pframes_ff;
      free_in     = free_ff;
      rsp_valid_in = 1'b0;
      rsp_in      = rsp_ff;
      we          = 1'b0;
      wa          = addr_ff;
      wd          = '1;
      ra          = addr_ff;
      fin         = 1'b0;
      fin_status  = ST_OK;
      fin_frame   = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (op_type'(req_data.opcode))
                  OP_ALLOC: begin
                     if (req_data.frame_count == '0 || cnt21 > n21) begin
                        fin = 1'b1;
                        fin_status = ST_NO_RUN;
                     end else begin
                        cnt_in   = NW'(req_data.frame_count);
                        run_in   = '0;
                        addr_in  = '0;
                        iss_in   = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  OP_RELEASE: begin
                     if (below || past) begin
                        fin = 1'b1;
                        fin_status = ST_OUT_RANGE;
                     end else begin
                        lo_in    = idx;
                        addr_in  = idx[XW-1:3];
                        going_in = 1'b0;
                        state_in = S_RRD;
                     end
                  end
                  OP_MARK: begin
                     if (req_data.frame_count == '0) begin
                        fin = 1'b1;
                     end else if (below || past || cnt_over) begin
                        fin = 1'b1;
                        fin_status = ST_OUT_RANGE;
                     end else begin
                        lo_in       = idx;
                        hi_in       = idx + XW'(req_data.frame_count) - XW'(1);
                        addr_in     = idx[XW-1:3];
                        is_alloc_in = 1'b0;
                        state_in    = S_PRD;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            we = 1'b1;
            wd = '1;
            if (addr_ff == LAST_WORD) begin
               free_in  = n;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_SCAN: begin
            if (iss_ff) begin
               dv_in = 1'b1;
               dw_in = addr_ff;
               if (addr_ff == last_w) begin
                  iss_in = 1'b0;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
            if (dv_ff) begin
               run_in = scan_run;
               if (scan_hit) begin
                  dv_in       = 1'b0;
                  lo_in       = scan_start;
                  hi_in       = scan_end;
                  addr_in     = scan_start[XW-1:3];
                  is_alloc_in = 1'b1;
                  state_in    = S_PRD;
               end else if (dw_ff == last_w) begin
                  dv_in      = 1'b0;
                  fin        = 1'b1;
                  fin_status = ST_NO_RUN;
               end
            end
         end
         S_PRD: begin
            state_in = S_PWR;
         end
         S_PWR: begin
            we      = 1'b1;
            wd      = paint_word;
            free_in = free_ff - NW'(paint_cnt);
            if (addr_ff == hi_ff[XW-1:3]) begin
               fin = 1'b1;
               if (is_alloc_ff) begin
                  fin_frame = base_ff + 20'(lo_ff);
               end
            end else begin
               addr_in  = addr_ff + AW'(1);
               state_in = S_PRD;
            end
         end
         S_RRD: begin
            state_in = S_RWR;
         end
         S_RWR: begin
            if (rel_nothead) begin
               fin        = 1'b1;
               fin_status = ST_NOT_HEAD;
            end else begin
               we       = 1'b1;
               wd       = rel_word;
               free_in  = free_ff + NW'(rel_cnt);
               going_in = rel_going;
               if (rel_going && next_first < n) begin
                  addr_in  = addr_ff + AW'(1);
                  state_in = S_RRD;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_in.result_frame = fin_frame;
         rsp_in.status       = fin_status;
         rsp_in.free_frames  = 15'(free_in);
      end

      if (csr_valid && (csr_index == CSR_POOL_BASE || csr_index == CSR_POOL_FRAMES)) begin
         if (csr_index == CSR_POOL_BASE) begin
            base_in = csr_data;
         end else begin
            pframes_in = csr_data[14:0];
         end
         state_in = S_CLEAR;
         addr_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         dv_ff        <= 1'b0;
         iss_ff       <= 1'b0;
         going_ff     <= 1'b0;
         is_alloc_ff  <= 1'b0;
         base_ff      <= '0;
         pframes_ff   <= 15'd16384;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         dv_ff        <= dv_in;
         iss_ff       <= iss_in;
         going_ff     <= going_in;
         is_alloc_ff  <= is_alloc_in;
         base_ff      <= base_in;
         pframes_ff   <= pframes_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dw_ff  <= dw_in;
      run_ff <= run_in;
      cnt_ff <= cnt_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      rsp_ff <= rsp_in;
   end

   // frame state memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
`default_nettype wire

### hdl/cfa_checker.sv
// checker: port-level properties of the frame allocator, bound to the top level
`default_nettype none
module cfa_checker import cfa_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("no clearing pass after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request taken without work or response");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("response without a request");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.result_frame == '0))
      else $error("failed request returns a frame");

endmodule

bind contiguous_frame_allocator_unit cfa_checker u_cfa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

### sim/contiguous_frame_allocator_unit_tb.sv
// testbench: contiguous frame allocator checked against a frame state predictor
`timescale 1ns / 100ps
`default_nettype none
module contiguous_frame_allocator_unit_tb;
   import cfa_pkg::*;

   localparam int POOL_MAX  = 16384;
   localparam int IDLE_LIMIT = 60000;
   localparam int PHASE_REQS = 40;

   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type rs;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = CSR_POOL_BASE;
   logic [19:0] csr_data = '0;

   logic [1:0]  frame_st [POOL_MAX];
   int          free_cnt;
   logic [19:0] pool_base_q;
   int          pool_frames_q;
   rsp_type     rsp_expected [$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;

   dir_row_type dir_tab [18] = '{
      '{'{OP_RELEASE, 20'd0, 15'd1}, 1'b1, '{20'd0, ST_NOT_HEAD, 15'd16384}},
      '{'{OP_ALLOC, 20'd0, 15'd0}, 1'b1, '{20'd0, ST_NO_RUN, 15'd16384}},
      '{'{OP_ALLOC, 20'hFFFFF, 15'h7FFF}, 1'b1, '{20'd0, ST_NO_RUN, 15'd16384}},
      '{'{OP_ALLOC, 20'd0, 15'd16384}, 1'b1, '{20'd0, ST_OK, 15'd0}},
      '{'{OP_ALLOC, 20'd0, 15'd1}, 1'b1, '{20'd0, ST_NO_RUN, 15'd0}},
      '{'{OP_RELEASE, 20'd0, 15'd0}, 1'b1, '{20'd0, ST_OK, 15'd16384}},
      '{'{OP_RELEASE, 20'd16384, 15'd1}, 1'b1, '{20'd0, ST_OUT_RANGE, 15'd16384}},
      '{'{OP_RELEASE, 20'hFFFFF, 15'd1}, 1'b1, '{20'd0, ST_OUT_RANGE, 15'd16384}},
      '{'{OP_MARK, 20'hFFFFF, 15'd1}, 1'b1, '{20'd0, ST_OUT_RANGE, 15'd16384}},
      '{'{OP_MARK, 20'd5, 15'd0}, 1'b1, '{20'd0, ST_OK, 15'd16384}},
      '{'{OP_MARK, 20'd0, 15'd16384}, 1'b1, '{20'd0, ST_OK, 15'd0}},
      '{'{OP_NONE, 20'hFFFFF, 15'h7FFF}, 1'b1, '{20'd0, ST_OK, 15'd0}},
      '{'{OP_RELEASE, 20'd0, 15'd0}, 1'b1, '{20'd0, ST_OK, 15'd16384}},
      '{'{OP_MARK, 20'd100, 15'd16285}, 1'b1, '{20'd0, ST_OUT_RANGE, 15'd16384}},
      '{'{OP_ALLOC, 20'd0, 15'd5}, 1'b0, '{20'd0, ST_OK, 15'd0}},
      '{'{OP_MARK, 20'd3, 15'd4}, 1'b0, '{20'd0, ST_OK, 15'd0}},
      '{'{OP_RELEASE, 20'd3, 15'd0}, 1'b0, '{20'd0, ST_OK, 15'd0}},
      '{'{OP_RELEASE, 20'd0, 15'd0}, 1'b0, '{20'd0, ST_OK, 15'd0}}
   };

   contiguous_frame_allocator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int active_frames();
      int n;
      n = (pool_frames_q > POOL_MAX) ? POOL_MAX : pool_frames_q;
      return n & ~3;
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < POOL_MAX; i++) frame_st[i] = FS_FREE;
      free_cnt = active_frames();
   endfunction

   function automatic rsp_type next_frame_state(req_type r);
      rsp_type p;
      int n, cnt, run, idx, first;
      p = '0;
      n = active_frames();
      cnt = int'(r.frame_count);
      first = int'(r.first_frame);
      run = 0;
      case (r.opcode)
         OP_ALLOC: begin
            p.status = ST_NO_RUN;
            if (cnt != 0 && cnt <= n) begin
               for (int i = 0; i < n; i++) begin
                  run = (frame_st[i] == FS_FREE) ? run + 1 : 0;
                  if (run == cnt) begin
                     idx = i + 1 - cnt;
                     for (int k = idx; k <= i; k++)
                        frame_st[k] = (k == idx) ? FS_HEAD : FS_ALLOC;
                     free_cnt -= cnt;
                     p.result_frame = 20'(int'(pool_base_q) + idx);
                     p.status = ST_OK;
                     break;
                  end
               end
            end
         end
         OP_RELEASE: begin
            idx = first - int'(pool_base_q);
            if (first < int'(pool_base_q) || idx >= n)
               p.status = ST_OUT_RANGE;
            else if (frame_st[idx] != FS_HEAD)
               p.status = ST_NOT_HEAD;
            else begin
               frame_st[idx] = FS_FREE;
               free_cnt++;
               for (int k = idx + 1; k < n && frame_st[k] == FS_ALLOC; k++) begin
                  frame_st[k] = FS_FREE;
                  free_cnt++;
               end
            end
         end
         OP_MARK: begin
            idx = first - int'(pool_base_q);
            if (cnt == 0)
               p.status = ST_OK;
            else if (first < int'(pool_base_q) || idx >= n || cnt > n - idx)
               p.status = ST_OUT_RANGE;
            else begin
               for (int k = idx; k < idx + cnt; k++) begin
                  if (frame_st[k] == FS_FREE) free_cnt--;
                  frame_st[k] = (k == idx) ? FS_HEAD : FS_ALLOC;
               end
            end
         end
         default: p.status = ST_OK;
      endcase
      p.free_frames = 15'(free_cnt);
      return p;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int n, k, cap, idx;
      n = active_frames();
      k = $urandom_range(0, 99);
      cap = (n < 4) ? 1 : ((n > 256) ? 32 : n / 2);
      idx = (n == 0) ? 0 : $urandom_range(0, n - 1);
      r.opcode = OP_ALLOC;
      r.first_frame = 20'($urandom);
      r.frame_count = 15'($urandom_range(1, cap));
      if (k < 8) begin
         r.opcode = 2'($urandom);
         r.frame_count = 15'($urandom);
      end else if (k < 45) begin
         r.opcode = OP_ALLOC;
      end else if (k < 80) begin
         r.opcode = OP_RELEASE;
         r.first_frame = 20'(int'(pool_base_q) + idx);
         for (int i = idx; i < n; i++)
            if (frame_st[i] == FS_HEAD && $urandom_range(0, 9) < 8) begin
               r.first_frame = 20'(int'(pool_base_q) + i);
               break;
            end
      end else begin
         r.opcode = OP_MARK;
         r.first_frame = 20'(int'(pool_base_q) + idx);
         if (k > 96) r.frame_count = 15'($urandom_range(1, n + 2));
      end
      return r;
   endfunction

   task automatic send(req_type r, bit typed, rsp_type rs);
      rsp_type p;
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      p = next_frame_state(r);
      rsp_expected.push_back(typed ? rs : p);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : 0;
      end else
         burst_left--;
   endtask

   task automatic drain();
      if (start) begin
         start <= 1'b0;
         @(posedge clock);
      end
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [19:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_POOL_BASE) pool_base_q = value;
      else pool_frames_q = int'(value[14:0]);
      clear_pool();
      do @(posedge clock); while (busy);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            if (rsp_data.result_frame !== rsp_expected[0].result_frame) begin
               $display("%0t: result_frame expected %h got %h", $time,
                        rsp_expected[0].result_frame, rsp_data.result_frame);
               errors++;
            end
            if (rsp_data.status !== rsp_expected[0].status) begin
               $display("%0t: status expected %0d got %0d", $time,
                        rsp_expected[0].status, rsp_data.status);
               errors++;
            end
            if (rsp_data.free_frames !== rsp_expected[0].free_frames) begin
               $display("%0t: free_frames expected %0d got %0d", $time,
                        rsp_expected[0].free_frames, rsp_data.free_frames);
               errors++;
            end
            void'(rsp_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [19:0] bases  [7];
      int          frames [7];
      bases  = '{20'd0, 20'hFFFF0, 20'h0, 20'hFFFFF, 20'h12345, 20'h0, 20'h0};
      frames = '{64, 32, 4, 0, 32767, 13, 16384};
      bases[2] = 20'($urandom);
      bases[5] = 20'($urandom);
      pool_base_q = '0;
      pool_frames_q = POOL_MAX;
      clear_pool();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy);

      foreach (dir_tab[i]) send(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rs);

      foreach (bases[p]) begin
         drain();
         csr_write(CSR_POOL_BASE, bases[p]);
         csr_write(CSR_POOL_FRAMES, 20'(frames[p]));
         for (int i = 0; i < PHASE_REQS; i++) send(random_request(), 1'b0, '0);
      end

      drain();
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
hdl/cfa_pkg.sv
hdl/contiguous_frame_allocator_unit.sv
hdl/cfa_checker.sv
sim/contiguous_frame_allocator_unit_tb.sv
